// ===== rtl/core/pdsel_pkg.sv =====
// Shared types, codes and constants of the sink offer selector.
package pdsel_pkg;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_VOLT = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_HRST = 2'd3;

	// Offer kinds reported in results.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_FIXED = 2'd1;
	localparam logic [1:0] KIND_PPS   = 2'd2;
	localparam logic [1:0] KIND_AVS   = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_KEEPALIVE = 3'd0;
	localparam logic [2:0] REG_PPS_MIN   = 3'd1;
	localparam logic [2:0] REG_PPS_CAP   = 3'd2;
	localparam logic [2:0] REG_AVS_MIN   = 3'd3;
	localparam logic [2:0] REG_AVS_CAP   = 3'd4;

	localparam logic [15:0] RST_KEEPALIVE = 16'd1000;
	localparam logic [15:0] RST_PPS_MIN   = 16'd3300;
	localparam logic [15:0] RST_PPS_CAP   = 16'd21000;
	localparam logic [15:0] RST_AVS_MIN   = 16'd15000;
	localparam logic [15:0] RST_AVS_CAP   = 16'd28000;

	localparam int DEF_SLOTS     = 13;
	localparam int DEF_LOW_SLOTS = 7;

	localparam logic [7:0]  VSEL_FIXED = 8'hFF;
	localparam logic [15:0] TICK_MAX   = 16'hFFFF;

	// x / 100 equals (x * RECIP_100) >> RECIP_SHIFT for any x below 2^17.
	localparam logic [17:0] RECIP_100   = 18'd167773;
	localparam int          RECIP_SHIFT = 24;

	// Offer current in mA for each 4-bit current code.
	localparam logic [12:0] CUR_MA [16] = '{
		13'd1000, 13'd1250, 13'd1500, 13'd1750, 13'd2000, 13'd2250, 13'd2500, 13'd2750,
		13'd3000, 13'd3250, 13'd3500, 13'd3750, 13'd4000, 13'd4250, 13'd4500, 13'd5000
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_FIN,
		ST_EMIT
	} pdsel_state_t;

	typedef struct packed {
		logic [15:0] pps_min;
		logic [15:0] pps_cap;
		logic [15:0] avs_min;
		logic [15:0] avs_cap;
	} pdsel_cfg_t;

	typedef struct packed {
		logic       start;
		logic       eval;
		logic [3:0] slot;
		logic       written;
		logic       cur_step;
		logic [3:0] cur_idx;
	} pdsel_scan_ctl_t;

	typedef struct packed {
		logic       pps_hit;
		logic [3:0] pps_slot;
		logic       avs_hit;
		logic [3:0] avs_slot;
		logic       fix_hit;
		logic [3:0] fix_slot;
		logic [3:0] fix_code;
		logic       fix_zero;
		logic [3:0] cur_code;
	} pdsel_scan_res_t;

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/core/pdsel_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pdsel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/pdsel_scan.sv =====
// Offer decoder and selection trackers fed one slot per cycle during a scan.
module pdsel_scan
	import pdsel_pkg::*;
#(
	parameter int LOW_RANGE_SLOTS = DEF_LOW_SLOTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pdsel_scan_ctl_t ctl,
	input  logic [15:0]     rd_word,
	input  logic [15:0]     target,
	input  logic [15:0]     imin,
	input  pdsel_cfg_t      cfg,
	output pdsel_scan_res_t res
);

	logic [15:0] word;
	logic        low;
	logic [3:0]  code;
	logic        cur_ok;
	logic [15:0] v100;
	logic [15:0] v200;
	logic [15:0] pps_max;
	logic [15:0] avs_max;
	logic        pps_match;
	logic        avs_match;
	logic        fix_match;
	logic [15:0] fix_d;
	logic [15:0] cur_d;

	logic        pps_hit_q;
	logic [3:0]  pps_slot_q;
	logic        avs_hit_q;
	logic [3:0]  avs_slot_q;
	logic        fix_hit_q;
	logic [3:0]  fix_slot_q;
	logic [3:0]  fix_code_q;
	logic [15:0] fix_d_q;
	logic [3:0]  cur_code_q;
	logic [15:0] cur_d_q;

	// A slot never written reads as an empty offer.
	assign word   = ctl.written ? rd_word : 16'd0;
	assign low    = (ctl.slot <= 4'(LOW_RANGE_SLOTS));
	assign code   = word[13:10];
	assign cur_ok = ({3'd0, CUR_MA[code]} >= imin);
	assign v100   = 16'(word[7:0]) * 16'd100;
	assign v200   = {v100[14:0], 1'b0};

	assign pps_max = (v100 > cfg.pps_cap) ? cfg.pps_cap : v100;
	assign avs_max = (v200 > cfg.avs_cap) ? cfg.avs_cap : v200;

	assign pps_match = word[15] && low && word[14] && cur_ok &&
		(target >= cfg.pps_min) && (target <= pps_max);
	assign avs_match = word[15] && !low && cur_ok &&
		(target >= cfg.avs_min) && (target <= avs_max);
	assign fix_match = word[15] && low && !word[14] && cur_ok;
	assign fix_d     = abs_diff(v100, target);

	assign cur_d = abs_diff({3'd0, CUR_MA[ctl.cur_idx]}, imin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_hit_q <= 1'b0;
			avs_hit_q <= 1'b0;
			fix_hit_q <= 1'b0;
		end else if (ctl.start) begin
			pps_hit_q <= 1'b0;
			avs_hit_q <= 1'b0;
			fix_hit_q <= 1'b0;
		end else if (ctl.eval) begin
			if (pps_match) begin
				pps_hit_q <= 1'b1;
			end
			if (avs_match) begin
				avs_hit_q <= 1'b1;
			end
			if (fix_match) begin
				fix_hit_q <= 1'b1;
			end
		end
	end

	// Slots arrive in ascending order, so the first match is kept and a
	// fixed offer replaces the best one only when strictly closer.
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			if (pps_match && !pps_hit_q) begin
				pps_slot_q <= ctl.slot;
			end
			if (avs_match && !avs_hit_q) begin
				avs_slot_q <= ctl.slot;
			end
			if (fix_match && (!fix_hit_q || (fix_d < fix_d_q))) begin
				fix_slot_q <= ctl.slot;
				fix_code_q <= code;
				fix_d_q    <= fix_d;
			end
		end
		if (ctl.cur_step && ((ctl.cur_idx == 4'd0) || (cur_d < cur_d_q))) begin
			cur_code_q <= ctl.cur_idx;
			cur_d_q    <= cur_d;
		end
	end

	assign res.pps_hit  = pps_hit_q;
	assign res.pps_slot = pps_slot_q;
	assign res.avs_hit  = avs_hit_q;
	assign res.avs_slot = avs_slot_q;
	assign res.fix_hit  = fix_hit_q;
	assign res.fix_slot = fix_slot_q;
	assign res.fix_code = fix_code_q;
	assign res.fix_zero = (fix_d_q == 16'd0);
	assign res.cur_code = cur_code_q;

endmodule

// ===== rtl/core/pd_sink_source_offer_selector.sv =====
// Top level of the sink offer selector: sequencer, offer memory, registers and output stage.
// A load passes through the load state (a bad slot is dropped at acceptance), a hard reset ends
// at acceptance, and a tick passes through the emit state only when it resends. A voltage request
// runs to the output register through a 16-step scan that reads one offer slot per cycle from the offer memory while
// the current code search walks its 16 entries, then through a select state and an emit state.
// One item is in work at a time; a finished result may wait in the output register.
// Reset is asynchronous; the table reads as empty through per-slot written flags.
module pd_sink_source_offer_selector
	import pdsel_pkg::*;
#(
	parameter int SLOTS           = DEF_SLOTS,
	parameter int LOW_RANGE_SLOTS = DEF_LOW_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: offer_slot[3:0], offer_word[19:4], target_mv[35:20],
	// min_current_ma[51:36], exact_only[52], zero fill [55:53]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// tuser: req_type[1:0]
	input  logic [1:0]  s_tuser,
	// tdata: request_word[15:0], chosen_slot[19:16], offer_kind[21:20],
	// word_sent[22], valid_offers[26:23], zero fill [31:27]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// tuser: is_repeat[0]
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(SLOTS);

	pdsel_state_t state_q;
	pdsel_state_t state_d;

	logic [15:0] keepalive_q;
	pdsel_cfg_t  cfg_q;

	logic [3:0]  slot_q;
	logic [15:0] word_q;
	logic [15:0] target_q;
	logic [15:0] imin_q;
	logic        exact_q;

	logic        repeat_q;
	logic [15:0] ticks_q;
	logic [15:0] held_q;
	logic [3:0]  count_q;
	logic [SLOTS-1:0] written_q;
	logic [3:0]  step_q;

	logic        eval_s1;
	logic [3:0]  slot_s1;
	logic        written_s1;

	logic [15:0] res_word_q;
	logic [3:0]  res_slot_q;
	logic [1:0]  res_kind_q;
	logic        res_sent_q;
	logic        res_rep_q;

	logic        out_valid_q;
	logic [15:0] out_word_q;
	logic [3:0]  out_slot_q;
	logic [1:0]  out_kind_q;
	logic        out_sent_q;
	logic        out_rep_q;
	logic [3:0]  out_count_q;

	logic        accept;
	logic [3:0]  in_slot;
	logic        in_slot_ok;
	logic        cfg_wr;
	logic        ram_we;
	logic [AW-1:0] ram_raddr;
	logic [15:0] ram_rdata;
	logic        scan_rd;
	logic [15:0] tick_next;
	logic        tick_fire;
	logic        emit_go;
	logic        scan_start;

	pdsel_scan_ctl_t scan_ctl;
	pdsel_scan_res_t scan_res;

	logic [16:0] dividend;
	logic [34:0] product;
	logic [1:0]  sel_kind;
	logic [3:0]  sel_slot;

	assign accept     = s_tvalid && s_tready;
	assign in_slot    = s_tdata[3:0];
	assign in_slot_ok = (in_slot != 4'd0) && (in_slot <= 4'(SLOTS));
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign pready     = 1'b1;
	assign emit_go    = !out_valid_q || m_tready;
	assign scan_rd    = (state_q == ST_SCAN) && (step_q < 4'(SLOTS));

	assign tick_next = (ticks_q == TICK_MAX) ? ticks_q : (ticks_q + 16'd1);
	assign tick_fire = repeat_q && (tick_next >= keepalive_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_q   <= RST_KEEPALIVE;
			cfg_q.pps_min <= RST_PPS_MIN;
			cfg_q.pps_cap <= RST_PPS_CAP;
			cfg_q.avs_min <= RST_AVS_MIN;
			cfg_q.avs_cap <= RST_AVS_CAP;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_KEEPALIVE: keepalive_q   <= pwdata[15:0];
				REG_PPS_MIN:   cfg_q.pps_min <= pwdata[15:0];
				REG_PPS_CAP:   cfg_q.pps_cap <= pwdata[15:0];
				REG_AVS_MIN:   cfg_q.avs_min <= pwdata[15:0];
				REG_AVS_CAP:   cfg_q.avs_cap <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_KEEPALIVE: prdata = {16'd0, keepalive_q};
			REG_PPS_MIN:   prdata = {16'd0, cfg_q.pps_min};
			REG_PPS_CAP:   prdata = {16'd0, cfg_q.pps_cap};
			REG_AVS_MIN:   prdata = {16'd0, cfg_q.avs_min};
			REG_AVS_CAP:   prdata = {16'd0, cfg_q.avs_cap};
			default:       prdata = 32'd0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		scan_start = 1'b0;
		ram_raddr  = AW'(step_q);
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = AW'(in_slot - 4'd1);
				if (accept) begin
					unique case (s_tuser)
						REQ_LOAD: begin
							if (in_slot_ok) begin
								state_d = ST_LOAD;
							end
						end
						REQ_VOLT: begin
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
						REQ_TICK: begin
							if (tick_fire) begin
								state_d = ST_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				ram_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (step_q == 4'd15) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q   <= in_slot;
			word_q   <= s_tdata[19:4];
			target_q <= s_tdata[35:20];
			imin_q   <= s_tdata[51:36];
			exact_q  <= s_tdata[52];
		end
	end

	pdsel_ram #(
		.WIDTH(16),
		.DEPTH(SLOTS)
	) u_offer_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(slot_q - 4'd1)),
		.wdata (word_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Load write-back: the old word read in the previous cycle corrects the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			count_q   <= 4'd0;
		end else if (ram_we) begin
			written_q[AW'(slot_q - 4'd1)] <= 1'b1;
			count_q <= count_q + {3'd0, word_q[15]}
				- {3'd0, written_q[AW'(slot_q - 4'd1)] & ram_rdata[15]};
		end
	end

	// Scan step counter and the stage that lines up with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= 4'd0;
			eval_s1    <= 1'b0;
			slot_s1    <= 4'd0;
			written_s1 <= 1'b0;
		end else begin
			if (scan_start) begin
				step_q <= 4'd0;
			end else if (state_q == ST_SCAN) begin
				step_q <= step_q + 4'd1;
			end
			eval_s1    <= scan_rd;
			slot_s1    <= step_q + 4'd1;
			written_s1 <= scan_rd ? written_q[AW'(step_q)] : 1'b0;
		end
	end

	assign scan_ctl.start    = scan_start;
	assign scan_ctl.eval     = eval_s1;
	assign scan_ctl.slot     = slot_s1;
	assign scan_ctl.written  = written_s1;
	assign scan_ctl.cur_step = (state_q == ST_SCAN);
	assign scan_ctl.cur_idx  = step_q;

	pdsel_scan #(
		.LOW_RANGE_SLOTS(LOW_RANGE_SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.rd_word (ram_rdata),
		.target  (target_q),
		.imin    (imin_q),
		.cfg     (cfg_q),
		.res     (scan_res)
	);

	// Final choice: PPS before AVS before fixed.
	always_comb begin
		if (scan_res.pps_hit) begin
			sel_kind = KIND_PPS;
			sel_slot = scan_res.pps_slot;
			dividend = {1'b0, target_q} + 17'd50;
		end else if (scan_res.avs_hit) begin
			sel_kind = KIND_AVS;
			sel_slot = scan_res.avs_slot;
			dividend = 17'(({1'b0, target_q} + 17'd100) >> 1);
		end else if (scan_res.fix_hit && (!exact_q || scan_res.fix_zero)) begin
			sel_kind = KIND_FIXED;
			sel_slot = scan_res.fix_slot;
			dividend = 17'd0;
		end else begin
			sel_kind = KIND_NONE;
			sel_slot = 4'd0;
			dividend = 17'd0;
		end
	end

	assign product = 35'(dividend) * 35'(RECIP_100);

	// Keep-alive state and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= 1'b0;
			ticks_q  <= 16'd0;
			held_q   <= 16'd0;
		end else if (accept && (s_tuser == REQ_HRST)) begin
			repeat_q <= 1'b0;
		end else if (accept && (s_tuser == REQ_TICK) && repeat_q) begin
			ticks_q <= tick_fire ? 16'd0 : tick_next;
		end else if (state_q == ST_FIN) begin
			case (sel_kind) inside
				KIND_PPS, KIND_AVS: begin
					held_q   <= {sel_slot, scan_res.cur_code,
						product[RECIP_SHIFT+7:RECIP_SHIFT]};
					repeat_q <= 1'b1;
					ticks_q  <= 16'd0;
				end
				KIND_FIXED: repeat_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == REQ_TICK)) begin
			res_word_q <= held_q;
			res_slot_q <= held_q[15:12];
			res_kind_q <= (held_q[15:12] <= 4'(LOW_RANGE_SLOTS)) ? KIND_PPS : KIND_AVS;
			res_sent_q <= 1'b1;
			res_rep_q  <= 1'b1;
		end else if (state_q == ST_FIN) begin
			res_slot_q <= sel_slot;
			res_kind_q <= sel_kind;
			res_sent_q <= (sel_kind != KIND_NONE);
			res_rep_q  <= 1'b0;
			case (sel_kind) inside
				KIND_PPS, KIND_AVS: res_word_q <= {sel_slot, scan_res.cur_code,
					product[RECIP_SHIFT+7:RECIP_SHIFT]};
				KIND_FIXED: res_word_q <= {sel_slot, scan_res.fix_code, VSEL_FIXED};
				default:    res_word_q <= 16'd0;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && emit_go) begin
			out_word_q  <= res_word_q;
			out_slot_q  <= res_slot_q;
			out_kind_q  <= res_kind_q;
			out_sent_q  <= res_sent_q;
			out_rep_q   <= res_rep_q;
			out_count_q <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_count_q, out_sent_q, out_kind_q, out_slot_q, out_word_q};
	assign m_tuser  = out_rep_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(SLOTS))
		else $error("valid offer count exceeds the number of slots");

	a_held_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(repeat_q) |-> (held_q[15:12] != 4'd0))
		else $error("keep-alive armed without a chosen slot");

	a_unsent_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[22]) |-> ((m_tdata[19:16] == 4'd0) && !m_tuser))
		else $error("unsent result carries a slot or repeat flag");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && (step_q == 4'd15)) |=> (state_q == ST_FIN))
		else $error("scan did not hand over to selection");
`endif

endmodule
